@@ hdl/dlrs_pkg.sv @@
// ----------------------------------------------------------------------------
// dlrs_pkg: shared types and constants for the decimal LSD radix sorter
// Command codes, radix constants and the digit-extraction helper.
// ----------------------------------------------------------------------------
package dlrs_pkg;

    localparam int DEFAULT_DEPTH = 1024;
    localparam int RADIX         = 10;
    localparam int MAX_DIGITS    = 10;

    // x / 10 == (x * RECIP10) >> DIV10_SHIFT for every 32-bit x
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    typedef logic [1:0]  cmd_t;
    typedef logic [31:0] word_t;
    typedef logic [3:0]  digit_t;
    typedef logic [3:0]  pass_t;

    localparam cmd_t CMD_LOAD = 2'd0;
    localparam cmd_t CMD_SORT = 2'd1;
    localparam cmd_t CMD_READ = 2'd2;

    // Place values 10^0 .. 10^9 as 34-bit constants.
    function automatic logic [33:0] place_of(input pass_t p);
        logic [33:0] r;
        begin
            unique case (p)
                4'd0: r = 34'd1;
                4'd1: r = 34'd10;
                4'd2: r = 34'd100;
                4'd3: r = 34'd1000;
                4'd4: r = 34'd10000;
                4'd5: r = 34'd100000;
                4'd6: r = 34'd1000000;
                4'd7: r = 34'd10000000;
                4'd8: r = 34'd100000000;
                4'd9: r = 34'd1000000000;
                default: r = 34'd1;
            endcase
            return r;
        end
    endfunction

endpackage

@@ hdl/dlrs_if.sv @@
// ----------------------------------------------------------------------------
// dlrs_in_if / dlrs_out_if: valid/ready channels of the sorter
// One word moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface dlrs_in_if;
    import dlrs_pkg::*;
    logic  valid;
    logic  ready;
    cmd_t  cmd;
    word_t value_in;
    modport source (output valid, output cmd, output value_in, input ready);
    modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

interface dlrs_out_if;
    import dlrs_pkg::*;
    logic  valid;
    logic  ready;
    word_t sorted_value;
    logic  is_last;
    logic  empty_res;
    modport source (output valid, output sorted_value, output is_last, output empty_res,
                    input ready);
    modport sink   (input valid, input sorted_value, input is_last, input empty_res,
                    output ready);
endinterface

@@ hdl/decimal_lsd_radix_sorter.sv @@
// ----------------------------------------------------------------------------
// decimal_lsd_radix_sorter: load, sort and stream back unsigned words
// Stable base-10 LSD radix sort over a synchronous value memory.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel: cmd LOAD appends value_in (dropped when DEPTH words are held),
//                cmd SORT orders the held words ascending and rewinds the read
//                pointer, cmd READ returns the next word on the out channel.
//   out channel: one word per READ: sorted_value, is_last on the final word,
//                empty_res (value 0) when reading past the end.
// Operation:
//   LOAD writes the value memory as it is taken. READ passes the memory read, then the output
//   register; the next word is accepted as soon as the output register is
//   free, so a stalled receiver holds in.ready low.
//   SORT: a maximum scan over the held words, then for each decimal digit p
//   (0 for units) of the maximum: clearing the buckets, counting, prefix sums,
//   scattering, copying back and advancing. The digit unit divides by ten
//   p times, one step a cycle. in.ready stays low meanwhile.
// Reset: counters, read pointer and control clear at once; the memories hold
//   garbage that is never read because only entries below the count are used.
// ----------------------------------------------------------------------------
module decimal_lsd_radix_sorter
    import dlrs_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input logic        clk,
    input logic        rst_n,
    dlrs_in_if.sink    in,
    dlrs_out_if.source out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAX    = 4'd2;
    localparam logic [3:0] S_CLR    = 4'd3;
    localparam logic [3:0] S_CNT    = 4'd4;
    localparam logic [3:0] S_CNTD   = 4'd5;
    localparam logic [3:0] S_PFX    = 4'd6;
    localparam logic [3:0] S_SCT    = 4'd7;
    localparam logic [3:0] S_SCTD   = 4'd8;
    localparam logic [3:0] S_CPY    = 4'd9;
    localparam logic [3:0] S_NEXT   = 4'd10;
    localparam logic [3:0] S_RDMEM  = 4'd11;

    // Memories
    word_t vmem [DEPTH];
    word_t smem [DEPTH];
    word_t vrd_reg, srd_reg;
    logic          vwe, swe;
    logic [AW-1:0] vwa, vra, swa, sra;
    word_t         vwd, swd;

    always_ff @(posedge clk)
    begin
        if (vwe)
            vmem[vwa] <= vwd;
        vrd_reg <= vmem[vra];
        if (swe)
            smem[swa] <= swd;
        srd_reg <= smem[sra];
    end

    // Control
    logic [3:0]    st_reg, st_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic [CW-1:0] idx_reg, idx_next;
    word_t         max_reg, max_next;
    pass_t         pass_reg, pass_next;
    digit_t        bsel_reg, bsel_next;
    logic [CW-1:0] bkt_reg [RADIX];
    logic [CW-1:0] bkt_next [RADIX];
    logic          ov_reg, ov_next;
    word_t         ov_val_reg, ov_val_next;
    logic          ov_last_reg, ov_last_next;
    logic          ov_emp_reg, ov_emp_next;
    logic          last_pend_reg, last_pend_next;
    logic          dg_start;
    logic          dg_done;
    digit_t        dg;
    logic          ov_free;

    dlrs_digit u_digit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dg_start),
        .value (vrd_reg),
        .pass  (pass_reg),
        .done  (dg_done),
        .digit (dg)
    );

    assign ov_free   = !ov_reg || out.ready;
    assign in.ready  = (st_reg == S_IDLE) && ov_free;
    assign out.valid = ov_reg;
    assign out.sorted_value = ov_val_reg;
    assign out.is_last      = ov_last_reg;
    assign out.empty_res    = ov_emp_reg;

    always_comb
    begin
        st_next       = st_reg;
        cnt_next      = cnt_reg;
        rp_next       = rp_reg;
        idx_next      = idx_reg;
        max_next      = max_reg;
        pass_next     = pass_reg;
        bsel_next     = bsel_reg;
        bkt_next      = bkt_reg;
        ov_next       = ov_reg && !out.ready;
        ov_val_next   = ov_val_reg;
        ov_last_next  = ov_last_reg;
        ov_emp_next   = ov_emp_reg;
        last_pend_next = last_pend_reg;
        vwe = 1'b0; vwa = '0; vwd = '0;
        swe = 1'b0; swa = '0; swd = srd_reg;
        vra = idx_reg[AW-1:0];
        sra = idx_reg[AW-1:0];
        dg_start = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (in.valid && in.ready)
                begin
                    unique case (in.cmd)
                        CMD_LOAD:
                        begin
                            if (cnt_reg < CW'(DEPTH))
                            begin
                                vwe = 1'b1;
                                vwa = cnt_reg[AW-1:0];
                                vwd = in.value_in;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        CMD_SORT:
                        begin
                            rp_next  = '0;
                            idx_next = '0;
                            max_next = '0;
                            if (cnt_reg > CW'(1))
                                st_next = S_MAX;
                        end
                        CMD_READ:
                        begin
                            if (rp_reg < cnt_reg)
                            begin
                                vra = rp_reg[AW-1:0];
                                last_pend_next = (rp_reg + CW'(1) == cnt_reg);
                                rp_next = rp_reg + CW'(1);
                                st_next = S_RDMEM;
                            end
                            else
                            begin
                                ov_next      = 1'b1;
                                ov_val_next  = '0;
                                ov_last_next = 1'b0;
                                ov_emp_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            // drop the unused code
                        end
                    endcase
                end
            end
            S_RDMEM:
            begin
                ov_next      = 1'b1;
                ov_val_next  = vrd_reg;
                ov_last_next = last_pend_reg;
                ov_emp_next  = 1'b0;
                st_next      = S_IDLE;
            end
            S_MAX:
            begin
                // issue read idx, compare the word read last cycle
                if (idx_reg != '0 && vrd_reg > max_reg)
                    max_next = vrd_reg;
                if (idx_reg == cnt_reg)
                begin
                    pass_next  = '0;
                    st_next    = (max_next == '0) ? S_IDLE : S_CLR;
                    idx_next   = '0;
                end
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_CLR:
            begin
                for (int b = 0; b < RADIX; b++)
                    bkt_next[b] = '0;
                idx_next = '0;
                st_next  = S_CNT;
            end
            S_CNT:
            begin
                // word idx is in vrd_reg; launch the digit unit on it
                if (idx_reg == cnt_reg)
                begin
                    bsel_next = 4'd1;
                    st_next   = S_PFX;
                end
                else
                begin
                    dg_start = 1'b1;
                    st_next  = S_CNTD;
                end
            end
            S_CNTD:
            begin
                if (dg_done)
                begin
                    bkt_next[dg] = bkt_reg[dg] + CW'(1);
                    idx_next = idx_reg + CW'(1);
                    vra = idx_next[AW-1:0];
                    st_next = S_CNT;
                end
            end
            S_PFX:
            begin
                // one running sum a cycle
                bkt_next[bsel_reg] = bkt_reg[bsel_reg] + bkt_reg[bsel_reg - 4'd1];
                bsel_next = bsel_reg + 4'd1;
                if (bsel_reg == 4'(RADIX - 1))
                begin
                    idx_next = cnt_reg;
                    vra = cnt_reg[AW-1:0] - AW'(1);
                    st_next = S_SCT;
                end
            end
            S_SCT:
            begin
                vra = idx_reg[AW-1:0] - AW'(1);
                if (idx_reg == '0)
                begin
                    st_next = S_CPY;
                    sra = '0;
                end
                else
                begin
                    dg_start = 1'b1;
                    st_next = S_SCTD;
                end
            end
            S_SCTD:
            begin
                vra = idx_reg[AW-1:0] - AW'(1);
                if (dg_done)
                begin
                    swe = 1'b1;
                    swa = AW'(bkt_reg[dg] - CW'(1));
                    swd = vrd_reg;
                    bkt_next[dg] = bkt_reg[dg] - CW'(1);
                    idx_next = idx_reg - CW'(1);
                    vra = idx_next[AW-1:0] - AW'(1);
                    st_next = S_SCT;
                end
            end
            S_CPY:
            begin
                // smem read of idx issued last cycle; write it back
                sra = idx_reg[AW-1:0] + AW'(1);
                vwe = 1'b1;
                vwa = idx_reg[AW-1:0];
                vwd = srd_reg;
                if (idx_reg + CW'(1) == cnt_reg)
                    st_next = S_NEXT;
                idx_next = idx_reg + CW'(1);
            end
            S_NEXT:
            begin
                idx_next   = '0;
                vra        = '0;
                pass_next  = pass_reg + 4'd1;
                if (pass_reg == 4'(MAX_DIGITS - 1) ||
                    {2'b00, max_reg} < place_of(pass_reg + 4'd1))
                    st_next = S_IDLE;
                else
                    st_next = S_CLR;
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            cnt_reg       <= '0;
            rp_reg        <= '0;
            ov_reg        <= 1'b0;
            last_pend_reg <= 1'b0;
            for (int b = 0; b < RADIX; b++)
                bkt_reg[b] <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            rp_reg        <= rp_next;
            ov_reg        <= ov_next;
            last_pend_reg <= last_pend_next;
            bkt_reg       <= bkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        max_reg      <= max_next;
        pass_reg     <= pass_next;
        bsel_reg     <= bsel_next;
        ov_val_reg   <= ov_val_next;
        ov_last_reg  <= ov_last_next;
        ov_emp_reg   <= ov_emp_next;
    end

    // Assertions
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("count beyond depth");
    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= cnt_reg)
        else $error("read pointer beyond count");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> !(out.is_last && out.empty_res))
        else $error("last and empty together");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != S_IDLE |-> !in.ready)
        else $error("ready while busy");

endmodule

@@ hdl/dlrs_digit.sv @@
// ----------------------------------------------------------------------------
// dlrs_digit: multi-cycle decimal digit extractor
// Finds (value / 10^pass) % 10 by dividing by ten once a cycle.
// ----------------------------------------------------------------------------
module dlrs_digit
    import dlrs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  word_t  value,
    input  pass_t  pass,
    output logic   done,
    output digit_t digit
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    pass_t       left_reg, left_next;
    word_t       x_reg, x_next;
    digit_t      digit_reg, digit_next;
    logic [63:0] prod;
    word_t       quo;
    word_t       rem;

    // divide by ten with a reciprocal multiply; last step keeps the remainder
    always_comb
    begin
        prod       = 64'(x_reg) * 64'(RECIP10);
        quo        = 32'(prod >> DIV10_SHIFT);
        rem        = x_reg - ((quo << 3) + (quo << 1));
        busy_next  = busy_reg;
        left_next  = left_reg;
        x_next     = x_reg;
        digit_next = digit_reg;
        done_next  = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            left_next = pass;
            x_next    = value;
        end
        else if (busy_reg)
        begin
            if (left_reg != '0)
            begin
                x_next    = quo;
                left_next = left_reg - 4'd1;
            end
            else
            begin
                digit_next = rem[3:0];
                done_next  = 1'b1;
                busy_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        x_reg     <= x_next;
        digit_reg <= digit_next;
    end

    assign done  = done_reg;
    assign digit = digit_reg;

endmodule
